// ----- design/alc_pkg.sv -----
`timescale 1ns / 1ps
// alc_pkg: shared types, operation codes and sizes for the array list engine
// no dependencies; used by alc_cell, array_list_engine and the testbench

package alc_pkg;

  localparam int DATA_W          = 32;
  localparam int CNT_W           = 5;
  localparam int IDX_W           = 4;
  localparam int OP_W            = 3;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_LAST  = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_AT    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_AT   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

  // per-cycle command broadcast to every cell, flags already qualified
  typedef struct packed {
    logic              ins_front;
    logic              append;
    logic              rem_at;
    logic [CNT_W-1:0]  held;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- design/alc_cell.sv -----
`timescale 1ns / 1ps
// alc_cell: one storage cell of the list chain, takes from either neighbor
// depends on alc_pkg (cell_ctl_t)

module alc_cell #(
  parameter int POS = 0
) (
  input  logic                          clk,
  input  alc_pkg::cell_ctl_t            ctl,
  input  logic [alc_pkg::DATA_W-1:0]    prev_val,
  input  logic [alc_pkg::DATA_W-1:0]    next_val,
  output logic [alc_pkg::DATA_W-1:0]    val
);

  logic [alc_pkg::DATA_W-1:0] val_r;
  logic [alc_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    priority if (ctl.ins_front) begin
      // shift up, new value enters at the head
      val_nxt = (POS == 0) ? ctl.value : prev_val;
    end else if (ctl.append && (int'(ctl.held) == POS)) begin
      val_nxt = ctl.value;
    end else if (ctl.rem_at && (POS >= int'(ctl.idx))) begin
      // close the gap from above
      val_nxt = next_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- design/array_list_engine.sv -----
`timescale 1ns / 1ps
// array_list_engine: bounded ordered list of signed 32-bit values in a chain of cells
// depends on alc_pkg and alc_cell
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------------------
//  in_      | slave     | in_tvalid / in_tready        | in_tdata: op, value, index
//  out_     | master    | out_tvalid / out_tready      | out_tdata: ok, read_value, count,
//           |           |                              |   empty_res, full_res
//  cfg_     | slave     | cfg_valid / cfg_ready        | cfg_data: capacity
//
// one item per clock: every cell moves in the same cycle, so an insert, remove or read
// finishes in the cycle of its transfer and its result sits in the output register the
// cycle after. the output register is the only stage; in_tready stays high while it is
// empty or being drained, so a stalled out_tready holds back the input side.
// reset (rst_n low, synchronous) empties the list and sets capacity to 16; cell
// contents are not cleared, only positions below the count are ever returned.

module array_list_engine #(
  parameter int MAX_ENTRIES = alc_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op [2:0], value [34:3], index [38:35], zero [39]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // ok [0], read_value [32:1], count [37:33],
                                  // empty_res [38], full_res [39]
  // capacity register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity [4:0]
);

  localparam int DW = alc_pkg::DATA_W;
  localparam int CW = alc_pkg::CNT_W;
  localparam int IW = alc_pkg::IDX_W;

  // largest count the 5-bit counter can be asked to hold
  localparam logic [CW-1:0] MAX_CLIP = (MAX_ENTRIES > 31) ? 5'd31 : CW'(MAX_ENTRIES);
  // positions an index can reach
  localparam int RD_N = (MAX_ENTRIES < (1 << IW)) ? MAX_ENTRIES : (1 << IW);

  // unpack input item
  logic [alc_pkg::OP_W-1:0] in_op;
  logic [DW-1:0]            in_value;
  logic [IW-1:0]            in_index;

  assign in_op    = in_tdata[2:0];
  assign in_value = in_tdata[34:3];
  assign in_index = in_tdata[38:35];

  // control state
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] cap_r;
  logic          out_tvalid_r;
  logic [39:0]   out_tdata_r;

  logic in_xfer;
  logic [CW-1:0] eff_cap;
  logic can_ins, idx_ok;
  logic res_ok;
  logic [DW-1:0] rd_val;
  alc_pkg::cell_ctl_t ctl;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // capacity clipped to the number of cells, at most 31
  assign eff_cap = (cap_r > MAX_CLIP) ? MAX_CLIP : cap_r;
  assign can_ins = held_r < eff_cap;
  assign idx_ok  = {1'b0, in_index} < held_r;

  // cell chain
  logic [DW-1:0] cell_val [MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    alc_cell #(
      .POS (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .prev_val ((g == 0) ? in_value : cell_val[(g == 0) ? 0 : g-1]),
      .next_val (cell_val[(g == MAX_ENTRIES-1) ? g : g+1]),
      .val      (cell_val[g])
    );
  end

  // read port, only the positions an index can name
  always_comb begin
    rd_val = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_index == IW'(k)) begin
        rd_val = cell_val[k];
      end
    end
  end

  // operation decode and next count
  always_comb begin
    held_nxt      = held_r;
    res_ok        = 1'b0;
    ctl.ins_front = 1'b0;
    ctl.append    = 1'b0;
    ctl.rem_at    = 1'b0;
    ctl.held      = held_r;
    ctl.idx       = in_index;
    ctl.value     = in_value;
    unique case (in_op)
      alc_pkg::OP_INS_FRONT: begin
        res_ok        = can_ins;
        ctl.ins_front = in_xfer && can_ins;
        if (can_ins) held_nxt = held_r + 1'b1;
      end
      alc_pkg::OP_APPEND: begin
        res_ok     = can_ins;
        ctl.append = in_xfer && can_ins;
        if (can_ins) held_nxt = held_r + 1'b1;
      end
      alc_pkg::OP_REM_LAST: begin
        res_ok = held_r != '0;
        if (held_r != '0) held_nxt = held_r - 1'b1;
      end
      alc_pkg::OP_REM_AT: begin
        res_ok     = idx_ok;
        ctl.rem_at = in_xfer && idx_ok;
        if (idx_ok) held_nxt = held_r - 1'b1;
      end
      alc_pkg::OP_READ_AT: begin
        res_ok = idx_ok;
      end
      alc_pkg::OP_CLEAR: begin
        res_ok   = 1'b1;
        held_nxt = '0;
      end
      default: begin
        // undefined op: refused, list untouched
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      cap_r        <= alc_pkg::CAP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (in_xfer) begin
        held_r       <= held_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_tdata_r <= {held_nxt >= eff_cap,
                      held_nxt == '0,
                      held_nxt,
                      (in_op == alc_pkg::OP_READ_AT && idx_ok) ? rd_val : {DW{1'b0}},
                      res_ok};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // count never goes past what the cells can hold
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= MAX_CLIP)
    else $error("list count exceeds cell count");

  // a pending result always reports the current count
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[37:33] == held_r))
    else $error("reported count differs from held count");

  // a successful append grows the list by exactly one
  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_op == alc_pkg::OP_APPEND && can_ins) |=>
      (held_r == $past(held_r) + 1'b1))
    else $error("append did not grow the list by one");

  // every transfer leaves a result waiting
  a_result_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid_r)
    else $error("accepted item produced no result");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for array_list_engine, a bounded ordered list of
// signed 32-bit values; depends on alc_pkg and the array_list_engine rtl

module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 160;
  localparam int MAX_SHOWN    = 40;

  // op codes the block leaves undefined
  localparam logic [alc_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [alc_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef enum int {GROW, MIXED, SHRINK} op_mix_t;

  // one pending item for the driver; drain holds the sender until all results are back
  typedef struct {
    bit                         drain;
    logic [alc_pkg::OP_W-1:0]   op;
    logic [alc_pkg::DATA_W-1:0] value;
    logic [alc_pkg::IDX_W-1:0]  index;
  } list_cmd_t;

  typedef struct packed {
    logic                       ok;
    logic [alc_pkg::DATA_W-1:0] read_value;
    logic [alc_pkg::CNT_W-1:0]  count;
    logic                       empty_res;
    logic                       full_res;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [39:0]               in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [39:0]               out_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [alc_pkg::CNT_W-1:0] cfg_data = '0;

  array_list_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted list contents and capacity register
  logic [alc_pkg::DATA_W-1:0] list_cells [alc_pkg::MAX_ENTRIES_DEF];
  int                         list_held = 0;
  logic [alc_pkg::CNT_W-1:0]  capacity_q = alc_pkg::CAP_RESET;

  list_cmd_t    cmd_q[$];
  list_result_t pending_results[$];

  int   mismatch_cnt = 0;
  int   result_cnt = 0;
  int   cycle_cnt = 0;
  logic in_fire = 1'b0;
  int   burst_left = 8;
  int   gap_left = 0;
  int   rcv_mode = 0;
  int   rcv_left = 0;

  task automatic report_mismatch(input string field, input logic [alc_pkg::DATA_W-1:0] want,
                                 input logic [alc_pkg::DATA_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) begin
      $display("mismatch on %s at result %0d: expected %h, got %h",
               field, result_cnt, want, got);
    end
  endtask

  // expected result of one list operation; updates the predicted list
  function automatic list_result_t list_apply(input logic [alc_pkg::OP_W-1:0] op,
                                              input logic [alc_pkg::DATA_W-1:0] val,
                                              input logic [alc_pkg::IDX_W-1:0] idx);
    list_result_t r;
    int lim;
    // capacity saturates at the number of cells
    lim = (int'(capacity_q) > alc_pkg::MAX_ENTRIES_DEF) ? alc_pkg::MAX_ENTRIES_DEF
                                                        : int'(capacity_q);
    r = '0;
    case (op)
      alc_pkg::OP_INS_FRONT: if (list_held < lim) begin
        for (int i = list_held; i > 0; i--) list_cells[i] = list_cells[i-1];
        list_cells[0] = val;
        list_held++;
        r.ok = 1'b1;
      end
      alc_pkg::OP_APPEND: if (list_held < lim) begin
        list_cells[list_held] = val;
        list_held++;
        r.ok = 1'b1;
      end
      alc_pkg::OP_REM_LAST: if (list_held > 0) begin
        list_held--;
        r.ok = 1'b1;
      end
      alc_pkg::OP_REM_AT: if (int'(idx) < list_held) begin
        for (int i = int'(idx); i + 1 < list_held; i++) list_cells[i] = list_cells[i+1];
        list_held--;
        r.ok = 1'b1;
      end
      alc_pkg::OP_READ_AT: if (int'(idx) < list_held) begin
        r.read_value = list_cells[idx];
        r.ok = 1'b1;
      end
      alc_pkg::OP_CLEAR: begin
        list_held = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count     = alc_pkg::CNT_W'(list_held);
    r.empty_res = (list_held == 0);
    r.full_res  = (list_held >= lim);
    return r;
  endfunction

  // sample the in, out and cfg handshakes at the rising edge; check first, then predict
  always @(posedge clk) begin
    list_result_t want;
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end else if (!rst_n) begin
      list_held  = 0;
      capacity_q = alc_pkg::CAP_RESET;
      in_fire   <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        result_cnt++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_tdata[alc_pkg::DATA_W-1:0]);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[0] !== want.ok)
            report_mismatch("ok", alc_pkg::DATA_W'(want.ok),
                            alc_pkg::DATA_W'(out_tdata[0]));
          if (out_tdata[32:1] !== want.read_value)
            report_mismatch("read_value", want.read_value, out_tdata[32:1]);
          if (out_tdata[37:33] !== want.count)
            report_mismatch("count", alc_pkg::DATA_W'(want.count),
                            alc_pkg::DATA_W'(out_tdata[37:33]));
          if (out_tdata[38] !== want.empty_res)
            report_mismatch("empty_res", alc_pkg::DATA_W'(want.empty_res),
                            alc_pkg::DATA_W'(out_tdata[38]));
          if (out_tdata[39] !== want.full_res)
            report_mismatch("full_res", alc_pkg::DATA_W'(want.full_res),
                            alc_pkg::DATA_W'(out_tdata[39]));
        end
      end
      if (cfg_valid && cfg_ready) capacity_q = cfg_data;
      if (in_tvalid && in_tready) begin
        pending_results.push_back(list_apply(in_tdata[2:0], in_tdata[34:3],
                                             in_tdata[38:35]));
      end
      in_fire <= in_tvalid && in_tready;
    end
  end

  // sender: bursts of random length with random gaps, driven at the falling edge
  always @(negedge clk) begin
    list_cmd_t c;
    bit send;
    send = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        if (cmd_q[0].drain) begin
          // hold off until every outstanding result has come back
          if (pending_results.size() == 0) void'(cmd_q.pop_front());
        end else begin
          c = cmd_q.pop_front();
          send = 1'b1;
          in_tdata <= {1'b0, c.index, c.value, c.op};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0:       gap_left = $urandom_range(10, 30);
              1:       gap_left = $urandom_range(1, 4);
              default: gap_left = 0;
            endcase
          end
        end
      end
      in_tvalid <= send;
    end
  end

  // receiver: stall pattern switches between modes of random length
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_left = $urandom_range(8, 120);
    end else begin
      rcv_left--;
    end
    case (rcv_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rcv_left % 5) != 0);
    endcase
  end

  // nothing queued, nothing on the wire, no result outstanding
  task automatic wait_list_idle();
    do @(posedge clk);
    while (cmd_q.size() != 0 || in_tvalid || pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [alc_pkg::CNT_W-1:0] cap);
    wait_list_idle();
    @(negedge clk);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_op(input logic [alc_pkg::OP_W-1:0] op,
                          input logic [alc_pkg::DATA_W-1:0] val,
                          input logic [alc_pkg::IDX_W-1:0] idx);
    list_cmd_t c;
    c.drain = 1'b0;
    c.op    = op;
    c.value = val;
    c.index = idx;
    cmd_q.push_back(c);
  endtask

  // random items whose op mix pushes the count up, down or around the middle
  task automatic queue_random_phase(input int n, input op_mix_t mix);
    list_cmd_t c;
    int r;
    int ins_w;
    int rem_w;
    ins_w = (mix == GROW) ? 30 : (mix == SHRINK) ? 12 : 22;
    rem_w = (mix == GROW) ? 8 : (mix == SHRINK) ? 22 : 14;
    for (int k = 0; k < n; k++) begin
      c.drain = 1'b0;
      r = $urandom_range(0, 99);
      if (r < ins_w)                     c.op = alc_pkg::OP_INS_FRONT;
      else if (r < 2 * ins_w)            c.op = alc_pkg::OP_APPEND;
      else if (r < 2 * ins_w + rem_w)    c.op = alc_pkg::OP_REM_LAST;
      else if (r < 2 * (ins_w + rem_w))  c.op = alc_pkg::OP_REM_AT;
      else if (r < 97)                   c.op = alc_pkg::OP_READ_AT;
      else if (r < 98)                   c.op = alc_pkg::OP_CLEAR;
      else                               c.op = r[0] ? OP_RSVD7 : OP_RSVD6;
      case ($urandom_range(0, 15))
        0:       c.value = 32'h8000_0000;
        1:       c.value = 32'h7fff_ffff;
        2:       c.value = 32'hffff_ffff;
        3:       c.value = '0;
        default: c.value = $urandom;
      endcase
      // low positions are hit more often so removes and reads mostly land
      c.index = $urandom_range(0, 1) ? alc_pkg::IDX_W'($urandom_range(0, 15))
                                     : alc_pkg::IDX_W'($urandom_range(0, 3));
      cmd_q.push_back(c);
      if ($urandom_range(0, 99) == 0) begin
        c.drain = 1'b1;
        cmd_q.push_back(c);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list: every remove and read is refused, undefined ops too
    write_capacity(5'd16);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd0);
    queue_op(alc_pkg::OP_REM_LAST, '0, 4'd0);
    queue_op(alc_pkg::OP_REM_AT, '0, 4'd0);
    queue_op(OP_RSVD6, 32'h1234_5678, 4'd15);
    queue_op(OP_RSVD7, 32'hffff_ffff, 4'd15);
    // extreme values, front inserts shift entries up
    queue_op(alc_pkg::OP_APPEND, 32'h7fff_ffff, 4'd0);
    queue_op(alc_pkg::OP_INS_FRONT, 32'h8000_0000, 4'd0);
    queue_op(alc_pkg::OP_APPEND, 32'h0000_0000, 4'd0);
    queue_op(alc_pkg::OP_INS_FRONT, 32'hffff_ffff, 4'd0);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd0);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd3);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd4);
    // remove in the middle shifts later entries down
    queue_op(alc_pkg::OP_REM_AT, '0, 4'd1);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd1);
    queue_op(alc_pkg::OP_REM_AT, '0, 4'd15);
    queue_op(alc_pkg::OP_REM_LAST, '0, 4'd0);
    queue_op(alc_pkg::OP_CLEAR, '0, 4'd0);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd0);

    // single-entry list: inserts after the first refused as full
    write_capacity(5'd1);
    queue_op(alc_pkg::OP_APPEND, 32'ha5a5_a5a5, 4'd0);
    queue_op(alc_pkg::OP_APPEND, 32'h5a5a_5a5a, 4'd0);
    queue_op(alc_pkg::OP_INS_FRONT, 32'h0000_0001, 4'd0);
    queue_op(alc_pkg::OP_READ_AT, '0, 4'd0);
    queue_op(alc_pkg::OP_REM_AT, '0, 4'd0);

    // zero capacity: full while empty, every insert refused
    write_capacity(5'd0);
    queue_op(alc_pkg::OP_INS_FRONT, 32'h0000_0002, 4'd0);
    queue_op(alc_pkg::OP_APPEND, 32'h0000_0003, 4'd0);

    // random phases; the count carries over, so lower settings start above capacity
    write_capacity(5'd16);
    queue_random_phase(PHASE_ITEMS, GROW);
    write_capacity(5'd3);
    queue_random_phase(PHASE_ITEMS, MIXED);
    write_capacity(5'd31);
    queue_random_phase(PHASE_ITEMS, GROW);
    write_capacity(5'd8);
    queue_random_phase(PHASE_ITEMS, MIXED);
    write_capacity(5'd1);
    queue_random_phase(PHASE_ITEMS, MIXED);
    write_capacity(5'd20);
    queue_random_phase(PHASE_ITEMS, GROW);
    write_capacity(5'd0);
    queue_random_phase(PHASE_ITEMS, SHRINK);
    write_capacity(5'd12);
    queue_random_phase(PHASE_ITEMS, MIXED);
    write_capacity(5'd16);
    queue_random_phase(PHASE_ITEMS, SHRINK);

    // one output stage, so waiting on past idle catches any stray transfer
    wait_list_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- array_list_engine.f -----
design/alc_pkg.sv
design/alc_cell.sv
design/array_list_engine.sv
verif/testbench.sv
